/* rtl/npc_pkg.sv */
// npc_pkg: shared types and constants of the nearest palette colour block
// depends on nothing; used by nearest_palette_color_pixel
`default_nettype none

package npc_pkg;

  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned FRAME_WIDTH     = 320;
  localparam int unsigned FRAME_HEIGHT    = 200;

  localparam int unsigned IDX_W  = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned SQ_W   = 2 * CHAN_W;
  localparam int unsigned DIST_W = SQ_W + 2;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned PROD_W = 8 + $clog2(FRAME_WIDTH + 1) + 1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  typedef struct packed {
    logic [CHAN_W-1:0] c0;
    logic [CHAN_W-1:0] c1;
    logic [CHAN_W-1:0] c2;
  } colour_t;

endpackage

`default_nettype wire

/* rtl/nearest_palette_color_pixel.sv */
// nearest_palette_color_pixel: palette store and nearest colour search
// depends on npc_pkg for constants, the state enum and the colour struct
//
// use: the input channel carries load words (op 0) and query words (op 1).
// a load writes one palette entry in the cycle it is accepted and gives no
// output word. a query scans every palette entry from the single palette
// memory, one read per cycle, through a read stage, a square stage and a
// sum and compare stage, then hands the nearest entry and the frame buffer
// address to the output register. the scan length sets the throughput;
// a load does not stall the input.
// the input is stalled while a query is searched. the output register holds
// the finished word while the receiver stalls; a new query may run meanwhile
// and waits at its end until the register is free.
// reset clears the control state and the output valid; the palette itself
// is undefined until loaded, and all entries must be loaded before a query.
`default_nettype none

module nearest_palette_color_pixel (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  entry_index_i,
  input  wire logic [8:0]  pos_x_i,
  input  wire logic [7:0]  pos_y_i,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [7:0]  nearest_o,
  output      logic [15:0] fb_addr_o
);

  localparam int unsigned IdxW  = npc_pkg::IDX_W;
  localparam int unsigned CntW  = npc_pkg::CNT_W;
  localparam int unsigned SqW   = npc_pkg::SQ_W;
  localparam int unsigned DistW = npc_pkg::DIST_W;
  localparam int unsigned ProdW = npc_pkg::PROD_W;

  npc_pkg::colour_t palette_mem [npc_pkg::PALETTE_ENTRIES];

  npc_pkg::state_e state_q, state_d;

  logic                in_acc;
  logic                wr_en;
  logic                rd_en;
  logic                out_free;
  logic                out_load;

  logic [CntW-1:0]     rd_cnt_q, rd_cnt_d;
  npc_pkg::colour_t    rd_data_q;
  npc_pkg::colour_t    query_q;
  logic [15:0]         addr_q;
  logic [ProdW-1:0]    addr_full;

  logic                v1_q, v2_q;
  logic [IdxW-1:0]     idx1_q, idx2_q;
  logic [SqW-1:0]      sq0_q, sq1_q, sq2_q;
  logic [DistW-1:0]    dist_sum;
  logic [DistW-1:0]    best_dist_q;
  logic [IdxW-1:0]     best_idx_q;
  logic                take_best;

  logic                out_valid_q;
  logic [7:0]          nearest_q;
  logic [15:0]         fb_addr_q;

  function automatic logic [npc_pkg::SQ_W-1:0] sq_diff(
    input logic [npc_pkg::CHAN_W-1:0] a,
    input logic [npc_pkg::CHAN_W-1:0] b
  );
    logic [npc_pkg::CHAN_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return npc_pkg::SQ_W'(d) * npc_pkg::SQ_W'(d);
  endfunction

  assign in_stall_o = (state_q != npc_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wr_en      = in_acc && (op_i == npc_pkg::OP_LOAD) &&
                      ({1'b0, entry_index_i} < 9'(npc_pkg::PALETTE_ENTRIES));
  assign rd_en      = (state_q == npc_pkg::ST_SCAN) &&
                      (rd_cnt_q < CntW'(npc_pkg::PALETTE_ENTRIES));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == npc_pkg::ST_FINISH) && out_free;

  assign addr_full  = ProdW'(pos_y_i) * ProdW'(npc_pkg::FRAME_WIDTH) + ProdW'(pos_x_i);

  assign dist_sum   = DistW'(sq0_q) + DistW'(sq1_q) + DistW'(sq2_q);
  assign take_best  = v2_q && ((idx2_q == '0) || (dist_sum < best_dist_q));

  always_comb begin
    state_d  = state_q;
    rd_cnt_d = rd_cnt_q;
    case (state_q)
      npc_pkg::ST_IDLE: begin
        if (in_acc && (op_i == npc_pkg::OP_QUERY)) begin
          state_d  = npc_pkg::ST_SCAN;
          rd_cnt_d = '0;
        end
      end
      npc_pkg::ST_SCAN: begin
        if (rd_en) begin
          rd_cnt_d = rd_cnt_q + CntW'(1);
        end else if (!v1_q && !v2_q) begin
          state_d = npc_pkg::ST_FINISH;
        end
      end
      npc_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = npc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = npc_pkg::ST_IDLE;
      end
    endcase
  end

  // palette memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      palette_mem[entry_index_i[IdxW-1:0]] <= '{c0: green_i, c1: blue_i, c2: red_i};
    end
    rd_data_q <= palette_mem[rd_cnt_q[IdxW-1:0]];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && (op_i == npc_pkg::OP_QUERY)) begin
      query_q <= '{c0: green_i, c1: blue_i, c2: red_i};
      addr_q  <= addr_full[15:0];
    end
    idx1_q <= rd_cnt_q[IdxW-1:0];
    idx2_q <= idx1_q;
    sq0_q  <= sq_diff(rd_data_q.c0, query_q.c0);
    sq1_q  <= sq_diff(rd_data_q.c1, query_q.c1);
    sq2_q  <= sq_diff(rd_data_q.c2, query_q.c2);
    if (take_best) begin
      best_dist_q <= dist_sum;
      best_idx_q  <= idx2_q;
    end
    if (out_load) begin
      nearest_q <= 8'(best_idx_q);
      fb_addr_q <= addr_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= npc_pkg::ST_IDLE;
      rd_cnt_q    <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_cnt_q <= rd_cnt_d;
      v1_q     <= rd_en;
      v2_q     <= v1_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign nearest_o   = nearest_q;
  assign fb_addr_o   = fb_addr_q;

  // checks
  a_rd_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_cnt_q <= CntW'(npc_pkg::PALETTE_ENTRIES))
    else $error("scan counter beyond palette");

  a_finish_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == npc_pkg::ST_FINISH) |-> (!v1_q && !v2_q && !rd_en))
    else $error("search finished with compares in flight");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == npc_pkg::ST_FINISH))
    else $error("output word raised outside finish");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != npc_pkg::ST_IDLE) |-> !wr_en)
    else $error("palette written during a search");

endmodule

`default_nettype wire
